// ===== src/utbd_pkg.sv =====
// utbd_pkg: shared types, constants and helper functions for the radix digit converter
// no dependencies
`default_nettype none

package utbd_pkg;

    // sizes of the value path and the digit store
    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;
    localparam int STEP_BITS  = 4;
    localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int QUO_W      = DIV_STEPS * STEP_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int CNT_W      = ADDR_W + 1;

    // field widths
    localparam int IN_W    = 64;
    localparam int RADIX_W = 6;
    localparam int REM_W   = RADIX_W;
    localparam int CHAR_W  = 7;
    localparam int OUT_W   = 8;

    // radix register limits
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // ascii mapping
    localparam logic [CHAR_W-1:0] ASCII_ZERO          = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LETTER_OFFSET = 7'd55;
    localparam logic [REM_W-1:0]  FIRST_LETTER_DIGIT  = 6'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_EMIT
    } utbd_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic digit_write;
        logic rd_issue;
        logic out_load;
    } utbd_cmd_t;

    typedef struct packed {
        logic step_last;
        logic quo_zero;
        logic cnt_last;
        logic rd_last;
        logic out_free;
    } utbd_stat_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < FIRST_LETTER_DIGIT) begin
            res = ASCII_ZERO + CHAR_W'(d);
        end else begin
            res = ASCII_LETTER_OFFSET + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/utbd_ctrl.sv =====
// utbd_ctrl: sequencing state machine for the radix digit converter
// depends on utbd_pkg
`default_nettype none

module utbd_ctrl
    import utbd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire utbd_stat_t stat,
    output utbd_cmd_t  cmd
);

    utbd_state_t state_reg;
    utbd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.step_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (stat.quo_zero || stat.cnt_last) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.rd_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_WRITE: begin
                cmd.digit_write = 1'b1;
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
            end
            ST_EMIT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/utbd_dpath.sv =====
// utbd_dpath: radix register, digit-serial divider, digit store and output register
// depends on utbd_pkg
`default_nettype none

module utbd_dpath
    import utbd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [RADIX_W-1:0] cfg_wdata,
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tlast,
    input  wire utbd_cmd_t         cmd,
    output utbd_stat_t             stat
);

    logic [RADIX_W-1:0] radix_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [QUO_W-1:0]   quo_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_dec;
    logic [REM_W-1:0]   rd_data_reg;
    logic               rd_last_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic [REM_W-1:0] digit_mem [MAX_DIGITS];

    assign cnt_dec = cnt_reg - CNT_W'(1);

    // STEP_BITS restoring division steps per cycle
    always_comb begin
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] rem_t;
        logic [QUO_W-1:0] quo_t;
        rem_t = rem_reg;
        quo_t = quo_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_t, quo_t[QUO_W-1]};
            quo_t = {quo_t[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg}) begin
                trial    = trial - {1'b0, radix_reg};
                quo_t[0] = 1'b1;
            end
            rem_t = trial[REM_W-1:0];
        end
        rem_next = rem_t;
        quo_next = quo_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            quo_reg   <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                radix_reg <= clamp_radix(cfg_wdata);
            end
            if (cmd.load) begin
                quo_reg  <= QUO_W'(s_tdata[VALUE_BITS-1:0]);
                rem_reg  <= '0;
                step_reg <= '0;
                cnt_reg  <= '0;
            end else if (cmd.div_step) begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + STEP_W'(1);
            end else if (cmd.digit_write) begin
                rem_reg  <= '0;
                step_reg <= '0;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end else if (cmd.rd_issue) begin
                cnt_reg <= cnt_dec;
            end
        end
    end

    // digit store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.digit_write) begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= rem_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= digit_mem[cnt_dec[ADDR_W-1:0]];
            rd_last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_char_reg <= digit_to_ascii(rd_data_reg);
            out_last_reg <= rd_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_char_reg);
    assign m_tlast  = out_last_reg;

    assign stat.step_last = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign stat.quo_zero  = (quo_reg == '0);
    assign stat.cnt_last  = (cnt_reg == CNT_W'(MAX_DIGITS - 1));
    assign stat.rd_last   = rd_last_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

// ===== src/unsigned_to_base_digits_top.sv =====
// unsigned_to_base_digits_top: top level of the radix digit converter
// depends on utbd_pkg, utbd_ctrl and utbd_dpath
`default_nettype none

// Converts each unsigned 64-bit input word into its digits in the base held
// in the radix register (2 to 36, reset 10; 0 and 1 act as 2, 37 and up act
// as 36) and sends them as ASCII characters, most significant first, one per
// output word, with tlast on the final character. Zero gives a single '0'.
// One value is worked on at a time: the digits come from a shared divider
// that retires 4 quotient bits per cycle, and each digit is stored once its
// division is done; the characters are then read back from the 64-entry
// digit store, each loaded into the output register once the sink has taken
// the one before. s_tready is high only between values; the next value is
// taken while the last character still waits in the output register. The
// radix register may be written only while idle.

module unsigned_to_base_digits_top
    import utbd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // radix register write
    input  wire logic               cfg_we,
    input  wire logic [RADIX_W-1:0] cfg_wdata,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [IN_W-1:0]    s_tdata,   // [63:0] value
    // output words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [OUT_W-1:0]        m_tdata,   // [6:0] digit_char, [7] zero
    output logic                    m_tlast    // last_digit
);

    utbd_cmd_t  cmd;
    utbd_stat_t stat;

    // sequencer: load, divide, store digit, then read back in reverse
    utbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // divider, digit store and output register
    utbd_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for unsigned_to_base_digits_top
// predicts the ascii digits of every value in its own code and checks each output word
// depends on utbd_pkg and unsigned_to_base_digits_top
`timescale 1ns / 1ps

module tb_top
    import utbd_pkg::*;
();

    // no handshake for this many cycles means the block hung
    localparam int STALL_LIMIT  = 20000;
    // long sink hold-off, enough for the block to fill up and block its input
    localparam int HOLD_CYCLES  = 1500;
    // quiet cycles before a radix write and at the end of the run
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT     = 17;

    localparam logic [CHAR_W-1:0] CHAR_DIGIT_BASE  = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 7'd55;  // 'A' minus ten
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS  = 6'd10;
    localparam logic [IN_W-1:0]   ALL_ONES         = {IN_W{1'b1}};

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [RADIX_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;    // [63:0] value
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;    // [6:0] digit_char, [7] zero
    logic               m_tlast;    // last_digit

    char_word_t         digits_due[$];
    logic [RADIX_W-1:0] radix_shadow;
    int                 mismatch_count = 0;
    int                 stall_cycles = 0;
    int                 send_idle_pct = IDLE_PCT;
    int                 sink_idle_pct = IDLE_PCT;
    int                 hold_requests = 0;
    int                 holds_served = 0;
    int                 hold_left = 0;

    unsigned_to_base_digits_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // radix as the block uses it: 0 and 1 act as 2, 37 and up act as 36
    function automatic logic [RADIX_W-1:0] working_radix();
        logic [RADIX_W-1:0] base;
        base = radix_shadow;
        if (base < 6'd2) begin
            base = 6'd2;
        end else if (base > 6'd36) begin
            base = 6'd36;
        end
        return base;
    endfunction

    // repeated division gives the digits lsd first; queue them msd first
    function automatic void queue_digits(input logic [IN_W-1:0] value);
        logic [IN_W-1:0] quo;
        logic [IN_W-1:0] base;
        logic [5:0]      lsd_first[$];
        logic [5:0]      d;
        char_word_t      w;
        base = IN_W'(working_radix());
        quo  = value;
        do begin
            lsd_first.push_back(6'(quo % base));
            quo = quo / base;
        end while (quo != 0 && lsd_first.size() < MAX_DIGITS);
        for (int k = lsd_first.size() - 1; k >= 0; k--) begin
            d = lsd_first[k];
            if (d < DECIMAL_DIGITS) begin
                w.ch = CHAR_DIGIT_BASE + CHAR_W'(d);
            end else begin
                w.ch = CHAR_LETTER_BASE + CHAR_W'(d);
            end
            w.last = (k == 0);
            digits_due.push_back(w);
        end
    endfunction

    // mostly values of random length, some all ones and some near a power of the radix
    function automatic logic [IN_W-1:0] random_value();
        logic [IN_W-1:0] base;
        logic [IN_W-1:0] pw;
        int              steps;
        base = IN_W'(working_radix());
        case ($urandom_range(9))
            0: return ALL_ONES;
            1, 2: begin
                pw = 1;
                steps = $urandom_range(1, 63);
                for (int i = 0; i < steps; i++) begin
                    if (pw > ALL_ONES / base) break;
                    pw = pw * base;
                end
                return $urandom_range(1) ? pw : pw - 1;
            end
            default: return {$urandom, $urandom} >> $urandom_range(IN_W);
        endcase
    endfunction

    // offers one value and returns once it is taken; valid stays up for the next one
    task automatic send_value(input logic [IN_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        queue_digits(value);
    endtask

    task automatic wait_all_digits();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digits_due.size() != 0) @(posedge aclk);
    endtask

    // radix writes only with the block idle
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_all_digits();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        radix_shadow = r;
    endtask

    // reset radix is decimal; zero, one digit, carry into two digits, full width
    task automatic test_reset_radix();
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(ALL_ONES);
        send_value(64'd12345678901234567890);
    endtask

    task automatic test_radix_extremes();
        // binary: longest runs, 64 digits
        write_radix(6'd2);
        send_value(64'd0);
        send_value(ALL_ONES);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd5);
        // base 36: letters up to 'Z'
        write_radix(6'd36);
        send_value(64'd35);
        send_value(64'd36);
        send_value(ALL_ONES);
        send_value(64'd0);
        // below range acts as binary
        write_radix(6'd0);
        send_value(64'd3);
        write_radix(6'd1);
        send_value(64'd1);
        // above range acts as base 36
        write_radix(6'd37);
        send_value(64'd35);
        write_radix(6'd63);
        send_value(ALL_ONES);
        write_radix(6'd16);
        send_value(64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_random_radix();
        logic [RADIX_W-1:0] picks[4] = '{6'd2, 6'd36, 6'd0, 6'd63};
        for (int ph = 0; ph < 8; ph++) begin
            write_radix(ph < 4 ? picks[ph] : RADIX_W'($urandom_range(63)));
            repeat (35) send_value(random_value());
        end
    endtask

    // a stretch with no idling on either side
    task automatic test_back_to_back();
        write_radix(RADIX_W'($urandom_range(2, 36)));
        send_idle_pct = 0;
        sink_idle_pct = 0;
        repeat (40) send_value(random_value());
        send_idle_pct = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // sink holds off while the sender keeps offering
    task automatic test_sink_backpressure();
        write_radix(RADIX_W'($urandom_range(2, 36)));
        hold_requests++;
        repeat (8) send_value(random_value());
    endtask

    // sender pauses until every digit is out, then resumes
    task automatic test_pause_and_resume();
        repeat (10) send_value(random_value());
        wait_all_digits();
        repeat (10) send_value(random_value());
    endtask

    // sink side: random tready plus the long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // every output word against the oldest predicted character
    always @(posedge aclk) begin : check_words
        char_word_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (digits_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
            end else begin
                due = digits_due.pop_front();
                if (m_tdata[CHAR_W-1:0] !== due.ch)
                    report_mismatch($sformatf("digit_char %h, want %h",
                                              m_tdata[CHAR_W-1:0], due.ch));
                if (m_tdata[OUT_W-1:CHAR_W] !== '0)
                    report_mismatch($sformatf("pad bits %b not zero", m_tdata[OUT_W-1:CHAR_W]));
                if (m_tlast !== due.last)
                    report_mismatch($sformatf("last_digit %b, want %b", m_tlast, due.last));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        radix_shadow = RADIX_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_radix();
        test_radix_extremes();
        test_random_radix();
        test_back_to_back();
        test_sink_backpressure();
        test_pause_and_resume();

        wait_all_digits();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (digits_due.size() != 0)
            report_mismatch($sformatf("%0d characters never came", digits_due.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== unsigned_to_base_digits_top.f =====
src/utbd_pkg.sv
src/utbd_ctrl.sv
src/utbd_dpath.sv
src/unsigned_to_base_digits_top.sv
tb/tb_top.sv
